[design/ookp_pkg.sv]
// Shared types, codes and constants for the OOK pulse train player.
`default_nettype none
package ookp_pkg;

    // Buffer geometry and job limits
    localparam int MAX_ENTRIES  = 512;
    localparam int ADDR_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int REPEAT_LIMIT = 10;

    // Field widths
    localparam int DUR_W   = 16;
    localparam int TIMER_W = 20;
    localparam int SUM_W   = 20;
    localparam int REP_W   = 4;
    localparam int JOB_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Register reset values
    localparam logic [TIMER_W-1:0] GAP_RESET     = 20'd20000;
    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 20'd5000;
    localparam logic [DUR_W-1:0]   MIN_RESET     = 16'd10;
    localparam logic [DUR_W-1:0]   MAX_RESET     = 16'd50000;
    localparam logic [SUM_W-1:0]   LIMIT_RESET   = 20'd250000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 3'd4;

    // Opcodes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_LOAD  = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;

    // Operation status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    // Job outcome codes
    localparam logic [1:0] OUT_NONE    = 2'd0;
    localparam logic [1:0] OUT_DONE    = 2'd1;
    localparam logic [1:0] OUT_STOPPED = 2'd2;
    localparam logic [1:0] OUT_FAILED  = 2'd3;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [DUR_W-1:0] duration_us;
        logic [REP_W-1:0] repeat_count;
        logic             pll_lock;
    } cmd_t;

    typedef struct packed {
        logic [TIMER_W-1:0] gap_ticks;
        logic [TIMER_W-1:0] lock_timeout_ticks;
        logic [DUR_W-1:0]   entry_min;
        logic [DUR_W-1:0]   entry_max;
        logic [SUM_W-1:0]   frame_limit;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DUR_W-1:0]  data;
    } ram_wr_t;

    typedef struct packed {
        logic             carrier_key;
        logic             radio_tx_on;
        logic [1:0]       op_status;
        logic             running;
        logic [JOB_W-1:0] job_number;
        logic [REP_W-1:0] frames_sent;
        logic [REP_W-1:0] frames_total;
        logic [CNT_W-1:0] entries_loaded;
        logic [1:0]       job_outcome;
        logic [SUM_W-1:0] frame_total_us;
    } result_t;

endpackage
`default_nettype wire

[design/ookp_entry_ram.sv]
// Duration buffer: single write port, one registered read port.
`default_nettype none
module ookp_entry_ram
    import ookp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DUR_W-1:0]  rd_data,
    input  wire ram_wr_t           wr
);

    logic [DUR_W-1:0] mem [MAX_ENTRIES];

    // Write an accepted entry
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[design/ookp_player.sv]
// Buffer bookkeeping and frame sequencer: executes one command per exec pulse.
`default_nettype none
module ookp_player
    import ookp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              exec,
    input  wire cmd_t              cmd,
    input  wire cfg_t              cfg,
    input  wire logic [DUR_W-1:0]  rd_data,
    output logic      [ADDR_W-1:0] rd_addr,
    output ram_wr_t                wr,
    output result_t                res
);

    typedef enum logic [1:0] {PH_IDLE, PH_LOCK, PH_PLAY, PH_GAP} phase_t;

    phase_t             phase_reg, phase_next;
    logic [ADDR_W-1:0]  play_index_reg, play_index_next;
    logic [DUR_W-1:0]   remaining_reg, remaining_next;
    logic [TIMER_W-1:0] wait_reg, wait_next;
    logic [REP_W-1:0]   frames_done_reg, frames_done_next;
    logic [REP_W-1:0]   frames_target_reg, frames_target_next;
    logic [JOB_W-1:0]   job_reg, job_next;
    logic               stop_reg, stop_next;
    logic [1:0]         outcome_reg, outcome_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               bad_reg, bad_next;
    logic [1:0]         status_reg, status_next;

    logic               run;
    logic [CNT_W-1:0]   next_index;
    logic [SUM_W:0]     sum_try;
    logic               load_bad;
    logic               start_bad;

    // Prefetch the entry a tick may need: next entry while playing, else entry 0
    assign rd_addr = (phase_reg == PH_PLAY) ? play_index_reg + 1'b1 : '0;

    assign run        = (phase_reg != PH_IDLE);
    assign next_index = CNT_W'(play_index_reg) + 1'b1;
    assign sum_try    = {1'b0, sum_reg} + (SUM_W + 1)'(cmd.duration_us);
    assign load_bad   = (count_reg >= CNT_W'(MAX_ENTRIES))
                     || (cmd.duration_us < cfg.entry_min)
                     || (cmd.duration_us > cfg.entry_max)
                     || (sum_try > {1'b0, cfg.frame_limit});
    assign start_bad  = (cmd.repeat_count == '0)
                     || (cmd.repeat_count > REP_W'(REPEAT_LIMIT))
                     || bad_reg
                     || (count_reg < CNT_W'(2));

    // Next state for the command held in cmd
    always_comb
    begin
        phase_next         = phase_reg;
        play_index_next    = play_index_reg;
        remaining_next     = remaining_reg;
        wait_next          = wait_reg;
        frames_done_next   = frames_done_reg;
        frames_target_next = frames_target_reg;
        job_next           = job_reg;
        stop_next          = stop_reg;
        outcome_next       = outcome_reg;
        count_next         = count_reg;
        sum_next           = sum_reg;
        bad_next           = bad_reg;
        status_next        = ST_OK;
        wr.en              = 1'b0;
        wr.addr            = count_reg[ADDR_W-1:0];
        wr.data            = cmd.duration_us;

        case (cmd.opcode)
            OP_TICK:
            begin
                // Frame boundary: stop, count down the gap, finish or power up
                if (phase_reg == PH_GAP)
                begin
                    if (stop_reg)
                    begin
                        outcome_next = OUT_STOPPED;
                        phase_next   = PH_IDLE;
                        stop_next    = 1'b0;
                    end
                    else if (wait_reg != '0)
                    begin
                        wait_next = wait_reg - 1'b1;
                    end
                    else if (frames_done_reg >= frames_target_reg)
                    begin
                        outcome_next = OUT_DONE;
                        phase_next   = PH_IDLE;
                        stop_next    = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_LOCK;
                        wait_next  = '0;
                    end
                end

                if (phase_next == PH_LOCK)
                begin
                    // Wait for lock, fail once the timeout has passed
                    if (cmd.pll_lock)
                    begin
                        phase_next      = PH_PLAY;
                        play_index_next = '0;
                        remaining_next  = rd_data;
                    end
                    else if (wait_next >= cfg.lock_timeout_ticks)
                    begin
                        outcome_next = OUT_FAILED;
                        phase_next   = PH_IDLE;
                        stop_next    = 1'b0;
                    end
                    else
                    begin
                        wait_next = wait_next + 1'b1;
                    end
                end
                else if (phase_next == PH_PLAY)
                begin
                    // Count down the entry, then advance or end the frame
                    if (remaining_reg > DUR_W'(1))
                    begin
                        remaining_next = remaining_reg - 1'b1;
                    end
                    else if (next_index >= count_reg || next_index >= CNT_W'(MAX_ENTRIES))
                    begin
                        frames_done_next = frames_done_reg + 1'b1;
                        phase_next       = PH_GAP;
                        wait_next        = cfg.gap_ticks;
                        play_index_next  = '0;
                        remaining_next   = '0;
                    end
                    else
                    begin
                        play_index_next = next_index[ADDR_W-1:0];
                        remaining_next  = rd_data;
                    end
                end
            end

            OP_LOAD:
            begin
                if (run)
                begin
                    status_next = ST_BUSY;
                end
                else if (load_bad)
                begin
                    bad_next    = 1'b1;
                    status_next = ST_BAD;
                end
                else
                begin
                    wr.en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_try[SUM_W-1:0];
                end
            end

            OP_CLEAR:
            begin
                if (run)
                begin
                    status_next = ST_BUSY;
                end
                else
                begin
                    count_next = '0;
                    sum_next   = '0;
                    bad_next   = 1'b0;
                end
            end

            OP_START:
            begin
                if (run)
                begin
                    status_next = ST_BUSY;
                end
                else if (start_bad)
                begin
                    status_next = ST_BAD;
                end
                else
                begin
                    job_next           = job_reg + 1'b1;
                    frames_done_next   = '0;
                    frames_target_next = cmd.repeat_count;
                    stop_next          = 1'b0;
                    outcome_next       = OUT_NONE;
                    phase_next         = PH_GAP;
                    wait_next          = '0;
                    play_index_next    = '0;
                    remaining_next     = '0;
                end
            end

            OP_STOP:
            begin
                if (!run)
                begin
                    status_next = ST_IGNORED;
                end
                else
                begin
                    stop_next = 1'b1;
                end
            end

            default:
            begin
                status_next = ST_IGNORED;
            end
        endcase

        if (!exec)
        begin
            wr.en = 1'b0;
        end
    end

    // Hold player state, update on exec
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            play_index_reg    <= '0;
            remaining_reg     <= '0;
            wait_reg          <= '0;
            frames_done_reg   <= '0;
            frames_target_reg <= '0;
            job_reg           <= '0;
            stop_reg          <= 1'b0;
            outcome_reg       <= OUT_NONE;
            count_reg         <= '0;
            sum_reg           <= '0;
            bad_reg           <= 1'b0;
            status_reg        <= ST_OK;
        end
        else if (exec)
        begin
            phase_reg         <= phase_next;
            play_index_reg    <= play_index_next;
            remaining_reg     <= remaining_next;
            wait_reg          <= wait_next;
            frames_done_reg   <= frames_done_next;
            frames_target_reg <= frames_target_next;
            job_reg           <= job_next;
            stop_reg          <= stop_next;
            outcome_reg       <= outcome_next;
            count_reg         <= count_next;
            sum_reg           <= sum_next;
            bad_reg           <= bad_next;
            status_reg        <= status_next;
        end
    end

    // Drive the result fields from the state
    always_comb
    begin
        res.carrier_key    = (phase_reg == PH_PLAY) && !play_index_reg[0];
        res.radio_tx_on    = (phase_reg == PH_LOCK) || (phase_reg == PH_PLAY);
        res.op_status      = status_reg;
        res.running        = run;
        res.job_number     = job_reg;
        res.frames_sent    = frames_done_reg;
        res.frames_total   = frames_target_reg;
        res.entries_loaded = count_reg;
        res.job_outcome    = outcome_reg;
        res.frame_total_us = sum_reg;
    end

endmodule
`default_nettype wire

[design/ook_pulse_train_player_core.sv]
// Top level of the OOK pulse train player: command handshake, registers, RAM and player.
// The result strobe is raised from done_reg after the S_EXEC state entered at the accepting edge.
// A new command is not accepted while busy, that is while the entry RAM data
// that is fetched at accept is used in the execute state.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Reset: registers take their defaults, buffer empty, player idle; RAM needs no clearing.
`default_nettype none
module ook_pulse_train_player_core
    import ookp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [2:0]            opcode,
    input  wire logic [DUR_W-1:0]      duration_us,
    input  wire logic [REP_W-1:0]      repeat_count,
    input  wire logic                  pll_lock,
    output logic                       done,
    output logic                       carrier_key,
    output logic                       radio_tx_on,
    output logic [1:0]                 op_status,
    output logic                       running,
    output logic [JOB_W-1:0]           job_number,
    output logic [REP_W-1:0]           frames_sent,
    output logic [REP_W-1:0]           frames_total,
    output logic [CNT_W-1:0]           entries_loaded,
    output logic [1:0]                 job_outcome,
    output logic [SUM_W-1:0]           frame_total_us,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic {S_IDLE, S_EXEC} ctrl_state_t;

    ctrl_state_t       state_reg;
    logic              done_reg;
    cmd_t              cmd_reg;
    cfg_t              cfg_reg;
    logic              accept;
    logic [ADDR_W-1:0] rd_addr;
    logic [DUR_W-1:0]  rd_data;
    ram_wr_t           wr;
    result_t           res;

    assign busy      = (state_reg == S_EXEC);
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign cfg_ready = 1'b1;

    // Sequence each transaction through fetch and execute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Capture the command fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.opcode       <= opcode;
            cmd_reg.duration_us  <= duration_us;
            cmd_reg.repeat_count <= repeat_count;
            cmd_reg.pll_lock     <= pll_lock;
        end
    end

    // Write configuration registers; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_ticks          <= GAP_RESET;
            cfg_reg.lock_timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.entry_min          <= MIN_RESET;
            cfg_reg.entry_max          <= MAX_RESET;
            cfg_reg.frame_limit        <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GAP:     cfg_reg.gap_ticks          <= cfg_data[TIMER_W-1:0];
                CFG_TIMEOUT: cfg_reg.lock_timeout_ticks <= cfg_data[TIMER_W-1:0];
                CFG_MIN:     cfg_reg.entry_min          <= cfg_data[DUR_W-1:0];
                CFG_MAX:     cfg_reg.entry_max          <= cfg_data[DUR_W-1:0];
                CFG_LIMIT:   cfg_reg.frame_limit        <= cfg_data[SUM_W-1:0];
                default:     cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    ookp_entry_ram u_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    ookp_player u_player (
        .clk     (clk),
        .rst_n   (rst_n),
        .exec    (busy),
        .cmd     (cmd_reg),
        .cfg     (cfg_reg),
        .rd_data (rd_data),
        .rd_addr (rd_addr),
        .wr      (wr),
        .res     (res)
    );

    assign carrier_key    = res.carrier_key;
    assign radio_tx_on    = res.radio_tx_on;
    assign op_status      = res.op_status;
    assign running        = res.running;
    assign job_number     = res.job_number;
    assign frames_sent    = res.frames_sent;
    assign frames_total   = res.frames_total;
    assign entries_loaded = res.entries_loaded;
    assign job_outcome    = res.job_outcome;
    assign frame_total_us = res.frame_total_us;

endmodule
`default_nettype wire

[design/ookp_checker.sv]
// Port-level checker for the OOK pulse train player, bound to the top level.
`default_nettype none
module ookp_checker
    import ookp_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  done,
    input wire logic                  carrier_key,
    input wire logic                  radio_tx_on,
    input wire logic [1:0]            op_status,
    input wire logic                  running,
    input wire logic [JOB_W-1:0]      job_number
);

    // An accepted transaction is followed by its result strobe
    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##2 done)
        else $error("result strobe missing after accept");

    // Strobe only follows an execute cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) && !busy)
        else $error("result strobe without execute cycle");

    // Carrier only keyed while the radio transmits, and radio only on in a job
    a_key_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (!carrier_key || radio_tx_on) && (!radio_tx_on || running))
        else $error("carrier or radio active outside a frame");

    // Busy status only reported while a job runs
    a_busy_running: assert property (@(posedge clk) disable iff (!rst_n)
        done && op_status == ST_BUSY |-> running)
        else $error("busy status while idle");

    // Job number moves only with a result, by one
    a_job_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(job_number) |-> done && job_number == $past(job_number) + 1'b1)
        else $error("job number changed unexpectedly");

endmodule

bind ook_pulse_train_player_core ookp_checker u_ookp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .carrier_key (carrier_key),
    .radio_tx_on (radio_tx_on),
    .op_status   (op_status),
    .running     (running),
    .job_number  (job_number)
);
`default_nettype wire
